[rtl/core/ectr_pkg.sv]
// shared types and codes for the event counter trace ring
`timescale 1ns / 1ps
package ectr_pkg;

  localparam int TS_W  = 48;
  localparam int CNT_W = 32;
  localparam int CMD_W = 3;
  localparam int COL_W = 5;
  localparam int WIN_W = 8;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_FRAME = 3'd1,
    CMD_MARK  = 3'd2,
    CMD_READ  = 3'd3,
    CMD_KEY   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OFF       = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_MARK      = 3'd2,
    ST_DELTA     = 3'd3,
    ST_DONE      = 3'd4,
    ST_DONE_NONE = 3'd5,
    ST_LIMIT     = 3'd6,
    ST_NO_DUMP   = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    REG_ENABLED = 2'd0,
    REG_COLUMNS = 2'd1,
    REG_SLOW    = 2'd2,
    REG_KEY     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_FRAME,
    OP_MARK,
    OP_READ
  } op_kind_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_COPY,
    BK_SETUP,
    BK_WALK,
    BK_TICK,
    BK_CRD,
    BK_CCMP,
    BK_ERD,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [COL_W-1:0]  column;
    logic [CNT_W-1:0]  amount;
    logic [TS_W-1:0]   timestamp;
  } op_t;

  typedef struct packed {
    logic              enabled;
    logic [COL_W-1:0]  columns_in_use;
    logic [CNT_W-1:0]  slow_frame_ticks;
    logic              marker_key_enabled;
  } cfg_t;

  typedef struct packed {
    status_t           status;
    logic [CNT_W-1:0]  mark_number;
    logic [WIN_W-1:0]  window_frames;
    logic [CNT_W-1:0]  frame_index;
    logic [CNT_W-1:0]  frame_ticks;
    logic [COL_W-1:0]  column_index;
    logic [CNT_W-1:0]  delta;
    logic              last;
  } res_t;

endpackage

[rtl/core/ectr_if.sv]
// input and output channel interfaces
`timescale 1ns / 1ps
interface ectr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [4:0]  column;
  logic [31:0] amount;
  logic [47:0] timestamp;
  logic        key_down;
  modport source(output valid, command, column, amount, timestamp, key_down, input ready);
  modport sink(input valid, command, column, amount, timestamp, key_down, output ready);
endinterface

interface ectr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] mark_number;
  logic [7:0]  window_frames;
  logic [31:0] frame_index;
  logic [31:0] frame_ticks;
  logic [4:0]  column_index;
  logic [31:0] delta;
  logic        last;
  modport source(output valid, status, mark_number, window_frames, frame_index,
                 frame_ticks, column_index, delta, last, input ready);
  modport sink(input valid, status, mark_number, window_frames, frame_index,
               frame_ticks, column_index, delta, last, output ready);
endinterface

[rtl/core/ectr_front.sv]
// front end: takes words, sorts out commands and queues operations
`timescale 1ns / 1ps
module ectr_front (
  input  logic          clk,
  input  logic          rst,
  input  ectr_pkg::cfg_t cfg,
  ectr_in_if.sink       in_ch,
  output ectr_pkg::op_t op,
  output logic          op_valid,
  input  logic          op_ready
);
  import ectr_pkg::*;

  logic       key_was_down;
  op_t        q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       take;
  logic       keep;
  logic       push;
  logic       pop;
  logic       key_live;
  op_t        cls;

  assign in_ch.ready = (count != 2'd2);
  assign take        = in_ch.valid && in_ch.ready;
  assign key_live    = cfg.enabled && cfg.marker_key_enabled;
  assign push        = take && keep;
  assign op_valid    = (count != 2'd0);
  assign pop         = op_valid && op_ready;
  assign op          = q[rd_ptr];

  // classify the incoming word
  always_comb begin
    cls.kind      = OP_ADD;
    cls.column    = in_ch.column;
    cls.amount    = in_ch.amount;
    cls.timestamp = in_ch.timestamp;
    keep          = 1'b0;
    case (cmd_t'(in_ch.command))
      CMD_ADD: begin
        keep = 1'b1;
      end
      CMD_FRAME: begin
        cls.kind = OP_FRAME;
        keep     = cfg.enabled;
      end
      CMD_MARK: begin
        cls.kind = OP_MARK;
        keep     = 1'b1;
      end
      CMD_READ: begin
        cls.kind = OP_READ;
        keep     = cfg.enabled;
      end
      CMD_KEY: begin
        cls.kind = OP_MARK;
        keep     = key_live && in_ch.key_down && !key_was_down;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // queue pointers and key edge tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      key_was_down <= 1'b0;
      wr_ptr       <= 1'b0;
      rd_ptr       <= 1'b0;
      count        <= 2'd0;
    end else begin
      if (take && cmd_t'(in_ch.command) == CMD_KEY && key_live) begin
        key_was_down <= in_ch.key_down;
      end
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

endmodule

[rtl/core/ectr_back.sv]
// back end: counters, frame ring and dump walk
`timescale 1ns / 1ps
module ectr_back #(
  parameter int COLUMNS     = 24,
  parameter int RING_FRAMES = 512,
  parameter int DUMP_FRAMES = 240,
  parameter int PRINT_LIMIT = 120
) (
  input  logic           clk,
  input  logic           rst,
  input  ectr_pkg::cfg_t cfg,
  input  ectr_pkg::op_t  op,
  input  logic           op_valid,
  output logic           op_ready,
  ectr_out_if.source     out_ch
);
  import ectr_pkg::*;

  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int CCW   = $clog2(COLUMNS + 1);
  localparam int SW    = $clog2(RING_FRAMES);
  localparam int DEPTH = RING_FRAMES * COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(PRINT_LIMIT + 1);
  localparam logic [6:0]    COLS7     = 7'(COLUMNS);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_BASE = AW'((RING_FRAMES - 1) * COLUMNS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(RING_FRAMES - 1);

  // storage
  logic [31:0]    live [COLUMNS];
  logic [31:0]    counts_mem [DEPTH];
  logic [31:0]    ticks_mem [RING_FRAMES];

  back_state_t    state, state_next;
  logic [31:0]    frames_written;
  logic [47:0]    last_ts;
  logic           have_last;
  logic [31:0]    marks;
  logic [31:0]    cursor;
  logic [31:0]    dump_end;
  logic [PW-1:0]  printed;
  logic           dump_open;
  logic [SW-1:0]  wslot;
  logic [AW-1:0]  wbase;
  logic [SW-1:0]  cslot;
  logic [AW-1:0]  cbase;
  logic [AW-1:0]  pbase;
  logic           prev;
  logic [31:0]    tick_q;
  logic [31:0]    cnt_a;
  logic [31:0]    cnt_b;
  logic [CCW-1:0] c;
  res_t           res_q;
  logic           out_valid;

  logic           slot_free;
  logic           emit;
  res_t           res;
  logic [4:0]     ncols;
  logic [CCW-1:0] ncols_c;
  logic [CCW-1:0] c_plus;
  logic [47:0]    diff48;
  logic [31:0]    len;
  logic [31:0]    have;
  logic [31:0]    want;
  logic [31:0]    wslot32;
  logic [31:0]    cslot_mark;
  logic           adv;
  logic           found;
  logic           c_clr;
  logic           c_inc;
  logic           tick_rd;
  logic           cnt_rd;

  assign slot_free = !out_valid || out_ch.ready;
  assign ncols     = ({2'b00, cfg.columns_in_use} > COLS7) ? COLS7[4:0] : cfg.columns_in_use;
  assign ncols_c   = CCW'(ncols);
  assign c_plus    = c + 1'b1;
  assign tick_rd   = (state == BK_WALK);
  assign cnt_rd    = (state == BK_CRD) || (state == BK_ERD);

  // frame length, saturated to 32 bits
  assign diff48 = op.timestamp - last_ts;
  assign len    = !have_last ? 32'd0 : ((diff48[47:32] != 16'd0) ? 32'hFFFF_FFFF : diff48[31:0]);

  // dump window from the newest frames
  assign have       = (frames_written < 32'(RING_FRAMES)) ? frames_written : 32'(RING_FRAMES);
  assign want       = (have < 32'(DUMP_FRAMES)) ? have : 32'(DUMP_FRAMES);
  assign wslot32    = 32'(wslot);
  assign cslot_mark = (wslot32 >= want) ? (wslot32 - want) : (wslot32 + 32'(RING_FRAMES) - want);

  // sequencer: next state, strobes and result word
  always_comb begin
    state_next        = state;
    op_ready          = 1'b0;
    emit              = 1'b0;
    adv               = 1'b0;
    found             = 1'b0;
    c_clr             = 1'b0;
    c_inc             = 1'b0;
    res.status        = ST_OFF;
    res.mark_number   = marks;
    res.window_frames = '0;
    res.frame_index   = '0;
    res.frame_ticks   = '0;
    res.column_index  = '0;
    res.delta         = '0;
    res.last          = 1'b1;
    case (state)
      BK_IDLE: begin
        if (op_valid) begin
          case (op.kind)
            OP_ADD: begin
              op_ready = 1'b1;
            end
            OP_FRAME: begin
              op_ready   = 1'b1;
              c_clr      = 1'b1;
              state_next = BK_COPY;
            end
            OP_MARK: begin
              if (slot_free) begin
                op_ready = 1'b1;
                emit     = 1'b1;
                if (cfg.enabled) begin
                  res.mark_number = marks + 32'd1;
                  if (frames_written == 32'd0) begin
                    res.status = ST_EMPTY;
                  end else begin
                    res.status        = ST_MARK;
                    res.window_frames = want[7:0];
                    state_next        = BK_SETUP;
                  end
                end
              end
            end
            OP_READ: begin
              if (slot_free) begin
                op_ready = 1'b1;
                if (!dump_open) begin
                  emit       = 1'b1;
                  res.status = ST_NO_DUMP;
                end else if (printed >= PW'(PRINT_LIMIT)) begin
                  emit       = 1'b1;
                  res.status = ST_LIMIT;
                end else begin
                  state_next = BK_WALK;
                end
              end
            end
            default: begin
              op_ready = 1'b1;
            end
          endcase
        end
      end
      BK_COPY: begin
        c_inc = 1'b1;
        if (c == CCW'(COLUMNS - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_SETUP: begin
        state_next = BK_IDLE;
      end
      BK_WALK: begin
        if (cursor == dump_end) begin
          if (slot_free) begin
            emit       = 1'b1;
            res.status = (printed != '0) ? ST_DONE : ST_DONE_NONE;
            state_next = BK_IDLE;
          end
        end else begin
          state_next = BK_TICK;
        end
      end
      BK_TICK: begin
        c_clr = 1'b1;
        if (tick_q > cfg.slow_frame_ticks) begin
          found      = 1'b1;
          state_next = BK_ERD;
        end else if (!prev || ncols == 5'd0) begin
          adv        = 1'b1;
          state_next = BK_WALK;
        end else begin
          state_next = BK_CRD;
        end
      end
      BK_CRD: begin
        state_next = BK_CCMP;
      end
      BK_CCMP: begin
        if (cnt_a != cnt_b) begin
          found      = 1'b1;
          c_clr      = 1'b1;
          state_next = BK_ERD;
        end else if (c_plus == ncols_c) begin
          adv        = 1'b1;
          state_next = BK_WALK;
        end else begin
          c_inc      = 1'b1;
          state_next = BK_CRD;
        end
      end
      BK_ERD: begin
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (slot_free) begin
          emit             = 1'b1;
          res.status       = ST_DELTA;
          res.frame_index  = cursor;
          res.frame_ticks  = tick_q;
          res.column_index = (ncols == 5'd0) ? 5'd0 : 5'(c);
          res.delta        = (prev && ncols != 5'd0) ? (cnt_a - cnt_b) : 32'd0;
          res.last         = (ncols == 5'd0) || (c_plus == ncols_c);
          if (res.last) begin
            adv        = 1'b1;
            state_next = BK_IDLE;
          end else begin
            c_inc      = 1'b1;
            state_next = BK_ERD;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // state register and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= BK_IDLE;
      frames_written <= '0;
      last_ts        <= '0;
      have_last      <= 1'b0;
      marks          <= '0;
      cursor         <= '0;
      dump_end       <= '0;
      printed        <= '0;
      dump_open      <= 1'b0;
      wslot          <= '0;
      wbase          <= '0;
      cslot          <= '0;
      cbase          <= '0;
      pbase          <= '0;
      prev           <= 1'b0;
      c              <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (c_clr) begin
        c <= '0;
      end else if (c_inc) begin
        c <= c_plus;
      end
      // frame end header
      if (state == BK_IDLE && op_valid && op.kind == OP_FRAME) begin
        last_ts   <= op.timestamp;
        have_last <= 1'b1;
        dump_open <= 1'b0;
      end
      // last column of the snapshot closes the frame
      if (state == BK_COPY && c == CCW'(COLUMNS - 1)) begin
        frames_written <= frames_written + 32'd1;
        wslot          <= (wslot == LAST_SLOT) ? '0 : wslot + 1'b1;
        wbase          <= (wbase == LAST_BASE) ? '0 : wbase + ROW_STEP;
      end
      // mark opens a window
      if (state == BK_IDLE && op_ready && op.kind == OP_MARK && cfg.enabled) begin
        marks <= marks + 32'd1;
        if (frames_written != 32'd0) begin
          cursor    <= frames_written - want;
          dump_end  <= frames_written;
          printed   <= '0;
          dump_open <= 1'b1;
          cslot     <= cslot_mark[SW-1:0];
        end
      end
      if (state == BK_SETUP) begin
        cbase <= AW'(cslot) * ROW_STEP;
        pbase <= AW'((cslot == '0) ? LAST_SLOT : cslot - 1'b1) * ROW_STEP;
      end
      if (state == BK_IDLE && op_ready && op.kind == OP_READ && dump_open &&
          printed >= PW'(PRINT_LIMIT)) begin
        dump_open <= 1'b0;
      end
      if (state == BK_WALK) begin
        prev <= (cursor != 32'd0) && ((frames_written - cursor) < 32'(RING_FRAMES));
        if (cursor == dump_end && slot_free) begin
          dump_open <= 1'b0;
        end
      end
      if (found) begin
        printed <= printed + 1'b1;
      end
      // step to the next frame of the window
      if (adv) begin
        cursor <= cursor + 32'd1;
        cslot  <= (cslot == LAST_SLOT) ? '0 : cslot + 1'b1;
        pbase  <= cbase;
        cbase  <= (cbase == LAST_BASE) ? '0 : cbase + ROW_STEP;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (emit) begin
      res_q <= res;
    end
  end

  // live counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COLUMNS; i++) begin
        live[i] <= '0;
      end
    end else if (state == BK_IDLE && op_valid && op.kind == OP_ADD && op.column < ncols) begin
      live[CW'(op.column)] <= live[CW'(op.column)] + op.amount;
    end
  end

  // frame ring memories
  always_ff @(posedge clk) begin
    if (state == BK_IDLE && op_valid && op.kind == OP_FRAME) begin
      ticks_mem[wslot] <= len;
    end
    if (tick_rd) begin
      tick_q <= ticks_mem[cslot];
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_COPY) begin
      counts_mem[wbase + AW'(c)] <= live[CW'(c)];
    end
    if (cnt_rd) begin
      cnt_a <= counts_mem[cbase + AW'(c)];
      cnt_b <= counts_mem[pbase + AW'(c)];
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.status        = res_q.status;
  assign out_ch.mark_number   = res_q.mark_number;
  assign out_ch.window_frames = res_q.window_frames;
  assign out_ch.frame_index   = res_q.frame_index;
  assign out_ch.frame_ticks   = res_q.frame_ticks;
  assign out_ch.column_index  = res_q.column_index;
  assign out_ch.delta         = res_q.delta;
  assign out_ch.last          = res_q.last;

`ifndef ASSERT_OFF
  a_copy_range: assert property (@(posedge clk) disable iff (rst)
    state == BK_COPY |-> c <= CCW'(COLUMNS - 1))
    else $error("snapshot column out of range");

  a_print_bound: assert property (@(posedge clk) disable iff (rst)
    dump_open |-> printed <= PW'(PRINT_LIMIT))
    else $error("print count past limit");

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    dump_open && state == BK_IDLE |-> (dump_end - cursor) <= 32'(DUMP_FRAMES))
    else $error("dump window too long");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    cslot <= LAST_SLOT && wslot <= LAST_SLOT)
    else $error("ring slot out of range");
`endif

endmodule

[rtl/core/event_counter_trace_ring.sv]
// Event counter trace ring: adds are applied by the back end after the front-end queue.
// A frame end stores its tick count, then copies the live counters into the ring, one
// memory write per column. Plain status replies come from the idle state, a mark that
// opens a window passes a setup state; a dump step reads a frame's ticks, compares its
// columns and gives delta words. Reset is synchronous and clears all control state and
// live counters; the ring memories are not cleared, so no clearing pass follows reset.
`timescale 1ns / 1ps
module event_counter_trace_ring #(
  parameter int COLUMNS     = 24,
  parameter int RING_FRAMES = 512,
  parameter int DUMP_FRAMES = 240,
  parameter int PRINT_LIMIT = 120
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  ectr_in_if.sink     in_ch,
  ectr_out_if.source  out_ch
);
  import ectr_pkg::*;

  cfg_t cfg;
  op_t  op;
  logic op_valid;
  logic op_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ENABLED: cfg.enabled            <= cfg_data[0];
        REG_COLUMNS: cfg.columns_in_use     <= cfg_data[4:0];
        REG_SLOW:    cfg.slow_frame_ticks   <= cfg_data;
        REG_KEY:     cfg.marker_key_enabled <= cfg_data[0];
        default:     cfg <= cfg;
      endcase
    end
  end

  ectr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_ch    (in_ch),
    .op       (op),
    .op_valid (op_valid),
    .op_ready (op_ready)
  );

  ectr_back #(
    .COLUMNS     (COLUMNS),
    .RING_FRAMES (RING_FRAMES),
    .DUMP_FRAMES (DUMP_FRAMES),
    .PRINT_LIMIT (PRINT_LIMIT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .op       (op),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .out_ch   (out_ch)
  );

endmodule

[bench/tb_event_counter_trace_ring.sv]
// self-checking bench for the event counter trace ring
`timescale 1ns / 1ps
module tb_event_counter_trace_ring;
  import ectr_pkg::*;

  localparam int NCOL = 24;
  localparam int RING = 512;
  localparam int DUMP = 240;
  localparam int PLIM = 120;
  localparam int LIMIT_CYCLES = 1500000;

  typedef struct packed {
    cmd_t        command;
    logic [4:0]  column;
    logic [31:0] amount;
    logic [47:0] timestamp;
    logic        key_down;
  } word_t;

  // directed row: a word, and optionally a hand-typed first result
  typedef struct {
    word_t    w;
    bit       typed;
    status_t  st;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  ectr_in_if  in_ch();
  ectr_out_if out_ch();

  event_counter_trace_ring uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // predictor state
  logic        p_enabled;
  logic [4:0]  p_columns;
  logic [31:0] p_slow;
  logic        p_key_en;
  logic [31:0] live [NCOL];
  logic [31:0] snap_counts [RING][NCOL];
  logic [31:0] snap_ticks [RING];
  logic [31:0] frames_written;
  logic [47:0] last_ts;
  bit          have_last;
  bit          key_was_down;
  logic [31:0] marks_taken;
  logic [31:0] dump_cursor;
  logic [31:0] dump_end;
  int          printed;
  bit          dump_open;

  res_t expected_results[$];
  int   errors = 0;
  int   cycles = 0;
  bit   no_idle = 0;
  bit   hold_rx = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int used_cols();
    return (p_columns > NCOL) ? NCOL : int'(p_columns);
  endfunction

  function automatic void push_result(status_t st, logic [7:0] win, logic [31:0] fi,
                                      logic [31:0] ft, logic [4:0] col,
                                      logic [31:0] d, logic lst);
    res_t r;
    r.status = st; r.mark_number = marks_taken; r.window_frames = win;
    r.frame_index = fi; r.frame_ticks = ft; r.column_index = col;
    r.delta = d; r.last = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void open_window();
    logic [31:0] have, want;
    if (!p_enabled) begin
      push_result(ST_OFF, 0, 0, 0, 0, 0, 1);
      return;
    end
    marks_taken++;
    if (frames_written == 0) begin
      push_result(ST_EMPTY, 0, 0, 0, 0, 0, 1);
      return;
    end
    have = (frames_written < RING) ? frames_written : RING;
    want = (have < DUMP) ? have : DUMP;
    dump_cursor = frames_written - want;
    dump_end = frames_written;
    printed = 0;
    dump_open = 1;
    push_result(ST_MARK, want[7:0], 0, 0, 0, 0, 1);
  endfunction

  function automatic bit has_pred(logic [31:0] i);
    return i != 0 && (frames_written - i) < RING;
  endfunction

  function automatic bit frame_moved(logic [31:0] i);
    int s, p;
    s = i % RING;
    p = (i - 1) % RING;
    if (snap_ticks[s] > p_slow) return 1;
    if (!has_pred(i)) return 0;
    for (int c = 0; c < used_cols(); c++)
      if (snap_counts[s][c] != snap_counts[p][c]) return 1;
    return 0;
  endfunction

  function automatic void walk_dump();
    logic [31:0] i;
    int s, p, n;
    bit pr;
    if (!p_enabled) return;
    if (!dump_open) begin
      push_result(ST_NO_DUMP, 0, 0, 0, 0, 0, 1);
      return;
    end
    if (printed >= PLIM) begin
      dump_open = 0;
      push_result(ST_LIMIT, 0, 0, 0, 0, 0, 1);
      return;
    end
    while (dump_cursor != dump_end) begin
      i = dump_cursor;
      dump_cursor++;
      if (!frame_moved(i)) continue;
      s = i % RING;
      p = (i - 1) % RING;
      pr = has_pred(i);
      n = used_cols();
      printed++;
      if (n == 0) begin
        push_result(ST_DELTA, 0, i, snap_ticks[s], 0, 0, 1);
        return;
      end
      for (int c = 0; c < n; c++)
        push_result(ST_DELTA, 0, i, snap_ticks[s], c[4:0],
                    pr ? snap_counts[s][c] - snap_counts[p][c] : 32'd0, c == n - 1);
      return;
    end
    dump_open = 0;
    push_result(printed != 0 ? ST_DONE : ST_DONE_NONE, 0, 0, 0, 0, 0, 1);
  endfunction

  function automatic void predict_word(word_t w);
    logic [47:0] len;
    int s;
    case (w.command)
      CMD_ADD: if (w.column < used_cols()) live[w.column] += w.amount;
      CMD_FRAME: if (p_enabled) begin
        len = 0;
        if (have_last) len = w.timestamp - last_ts;
        if (len > 48'hFFFF_FFFF) len = 48'hFFFF_FFFF;
        last_ts = w.timestamp;
        have_last = 1;
        s = frames_written % RING;
        snap_ticks[s] = len[31:0];
        for (int c = 0; c < NCOL; c++) snap_counts[s][c] = live[c];
        frames_written++;
        dump_open = 0;
      end
      CMD_MARK: open_window();
      CMD_READ: walk_dump();
      CMD_KEY: if (p_enabled && p_key_en) begin
        if (w.key_down && !key_was_down) open_window();
        key_was_down = w.key_down;
      end
      default: ;
    endcase
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checker with bursty stalls
  initial begin
    int gap;
    out_ch.ready <= 0;
    @(posedge clk);
    forever begin
      if (hold_rx || (!no_idle && $urandom_range(0, 5) == 0)) begin
        out_ch.ready <= 0;
        gap = hold_rx ? 1 : $urandom_range(1, 16);
        repeat (gap) @(posedge clk);
      end else begin
        out_ch.ready <= 1;
        @(posedge clk);
        if (out_ch.valid && out_ch.ready) begin
          if (expected_results.size() == 0) begin
            report("unexpected word status", out_ch.status, 0);
          end else begin
            res_t e;
            e = expected_results.pop_front();
            if (out_ch.status != e.status) report("status", out_ch.status, e.status);
            if (out_ch.mark_number != e.mark_number)
              report("mark_number", out_ch.mark_number, e.mark_number);
            if (out_ch.window_frames != e.window_frames)
              report("window_frames", out_ch.window_frames, e.window_frames);
            if (out_ch.frame_index != e.frame_index)
              report("frame_index", out_ch.frame_index, e.frame_index);
            if (out_ch.frame_ticks != e.frame_ticks)
              report("frame_ticks", out_ch.frame_ticks, e.frame_ticks);
            if (out_ch.column_index != e.column_index)
              report("column_index", out_ch.column_index, e.column_index);
            if (out_ch.delta != e.delta) report("delta", out_ch.delta, e.delta);
            if (out_ch.last != e.last) report("last", out_ch.last, e.last);
          end
        end
      end
    end
  end

  // send one word, with random idle bursts ahead of it
  task automatic send(word_t w);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.command <= w.command;
    in_ch.column <= w.column;
    in_ch.amount <= w.amount;
    in_ch.timestamp <= w.timestamp;
    in_ch.key_down <= w.key_down;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_word(w);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (NCOL * 2 + 64) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_ENABLED: p_enabled = val[0];
      REG_COLUMNS: p_columns = val[4:0];
      REG_SLOW:    p_slow = val;
      REG_KEY:     p_key_en = val[0];
    endcase
  endtask

  function automatic word_t mk(cmd_t c, logic [4:0] col, logic [31:0] amt,
                               logic [47:0] ts, logic kd);
    word_t w;
    w.command = c; w.column = col; w.amount = amt; w.timestamp = ts; w.key_down = kd;
    return w;
  endfunction

  function automatic word_t rand_word(int mode);
    logic [47:0] ts;
    int r;
    ts = last_ts + $urandom_range(0, 3000);
    r = $urandom_range(0, 99);
    if (mode == 1 && r < 2) ts = 48'({$urandom(), $urandom()});
    if (r < 45)
      return mk(CMD_ADD, 5'($urandom_range(0, 31)),
                (r < 10) ? $urandom() : $urandom_range(0, 5), 0, 0);
    if (r < 65) return mk(CMD_FRAME, 0, 0, ts, 0);
    if (r < 70) return mk(CMD_MARK, 0, 0, 0, 0);
    if (r < 90) return mk(CMD_READ, 0, 0, 0, 0);
    if (r < 97) return mk(CMD_KEY, 0, 0, 0, 1'($urandom_range(0, 1)));
    return mk(cmd_t'($urandom_range(5, 7)), 5'($urandom()), $urandom(), ts, 1'($urandom()));
  endfunction

  initial begin
    row_t rows[$];
    int   snap;
    rst = 1;
    cfg_we = 0; cfg_index = REG_ENABLED; cfg_data = 0;
    in_ch.valid = 0; in_ch.command = CMD_ADD; in_ch.column = 0;
    in_ch.amount = 0; in_ch.timestamp = 0; in_ch.key_down = 0;
    p_enabled = 0; p_columns = 0; p_slow = 0; p_key_en = 0;
    for (int c = 0; c < NCOL; c++) live[c] = 0;
    frames_written = 0; last_ts = 0; have_last = 0; key_was_down = 0;
    marks_taken = 0; dump_cursor = 0; dump_end = 0; printed = 0; dump_open = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed table, first row answers while disabled
    rows.push_back('{mk(CMD_MARK, 0, 0, 0, 0), 1, ST_OFF});
    rows.push_back('{mk(CMD_READ, 0, 0, 0, 0), 0, ST_OFF});
    rows.push_back('{mk(CMD_FRAME, 0, 0, 48'd5, 0), 0, ST_OFF});
    foreach (rows[k]) begin
      if (rows[k].typed) begin
        res_t r;
        r = '0; r.status = rows[k].st; r.last = 1;
        snap = expected_results.size();
        send(rows[k].w);
        if (expected_results.size() != snap + 1 || expected_results[snap] != r)
          report("typed row", k, 0);
      end else
        send(rows[k].w);
    end
    drain();

    write_reg(REG_ENABLED, 1);
    write_reg(REG_COLUMNS, 24);
    write_reg(REG_SLOW, 32'd1000);
    write_reg(REG_KEY, 1);
    rows.delete();
    rows.push_back('{mk(CMD_MARK, 0, 0, 0, 0), 1, ST_EMPTY});
    rows.push_back('{mk(CMD_READ, 0, 0, 0, 0), 1, ST_NO_DUMP});
    rows.push_back('{mk(CMD_ADD, 23, 32'hFFFF_FFFF, 0, 0), 0, ST_OFF});
    rows.push_back('{mk(CMD_ADD, 24, 32'h5, 0, 0), 0, ST_OFF});
    rows.push_back('{mk(CMD_FRAME, 0, 0, 48'hFFFF_FFFF_FFFF, 0), 0, ST_OFF});
    rows.push_back('{mk(CMD_ADD, 23, 32'h2, 0, 0), 0, ST_OFF});
    rows.push_back('{mk(CMD_ADD, 0, 32'hAAAA_5555, 0, 0), 0, ST_OFF});
    rows.push_back('{mk(CMD_FRAME, 0, 0, 48'd10, 0), 0, ST_OFF});
    rows.push_back('{mk(CMD_FRAME, 0, 0, 48'd0, 0), 0, ST_OFF});
    rows.push_back('{mk(CMD_FRAME, 0, 0, 48'd20, 0), 0, ST_OFF});
    rows.push_back('{mk(CMD_KEY, 0, 0, 0, 1), 0, ST_OFF});
    rows.push_back('{mk(CMD_KEY, 0, 0, 0, 1), 0, ST_OFF});
    rows.push_back('{mk(CMD_READ, 0, 0, 0, 0), 0, ST_OFF});
    rows.push_back('{mk(CMD_READ, 0, 0, 0, 0), 0, ST_OFF});
    rows.push_back('{mk(CMD_MARK, 0, 0, 0, 0), 0, ST_OFF});
    rows.push_back('{mk(CMD_READ, 0, 0, 0, 0), 0, ST_OFF});
    rows.push_back('{mk(CMD_READ, 0, 0, 0, 0), 0, ST_OFF});
    rows.push_back('{mk(CMD_READ, 0, 0, 0, 0), 0, ST_OFF});
    rows.push_back('{mk(CMD_READ, 0, 0, 0, 0), 0, ST_OFF});
    rows.push_back('{mk(CMD_KEY, 0, 0, 0, 0), 0, ST_OFF});
    rows.push_back('{mk(cmd_t'(3'd7), 31, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1), 0, ST_OFF});
    foreach (rows[k]) begin
      if (rows[k].typed) begin
        snap = expected_results.size();
        send(rows[k].w);
        if (expected_results.size() != snap + 1 || expected_results[snap].status != rows[k].st)
          report("typed row", k, 0);
      end else
        send(rows[k].w);
    end

    // receiver holds off while the sender keeps offering words
    hold_rx = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_rx = 0;
      end
      begin
        send(mk(CMD_MARK, 0, 0, 0, 0));
        for (int k = 0; k < 8; k++) send(mk(CMD_READ, 0, 0, 0, 0));
      end
    join
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_reg(REG_COLUMNS, 0); write_reg(REG_SLOW, 32'hFFFF_FFFF); end
        1: begin write_reg(REG_COLUMNS, 31); write_reg(REG_SLOW, 0);
                 write_reg(REG_KEY, 0); end
        2: begin write_reg(REG_COLUMNS, 3); write_reg(REG_SLOW, 1500);
                 write_reg(REG_KEY, 1); end
        default: begin write_reg(REG_COLUMNS, 5); write_reg(REG_SLOW, 800);
                       no_idle = 1; end
      endcase
      for (int k = 0; k < 18; k++) send(rand_word(ph == 1 ? 1 : 0));
      if (ph == 2) begin
        drain();
        write_reg(REG_ENABLED, 0);
        for (int k = 0; k < 6; k++) send(rand_word(0));
        drain();
        write_reg(REG_ENABLED, 1);
      end
      drain();
    end

    if (errors == 0 && expected_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
